// ----- sv/bsc_pkg.sv -----
package bsc_pkg;

  localparam int NUM_PROCESSES = 8;
  localparam int COUNT_WIDTH   = 16;
  localparam int RES_TYPES     = 3;
  localparam int FIELD_W       = 16;
  localparam int ORDER_W       = 3;
  localparam int PROC_W        = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int ROWS_W        = $clog2(NUM_PROCESSES + 1);
  localparam int WORK_W        = COUNT_WIDTH + ROWS_W;
  localparam int IN_DATA_W     = 3 * RES_TYPES * FIELD_W;
  localparam int OUT_DATA_W    = 8;

  localparam logic OP_AVAIL = 1'b0;
  localparam logic OP_ROW   = 1'b1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [WORK_W-1:0]      work_t;
  typedef logic [PROC_W-1:0]      proc_t;
  typedef logic [ROWS_W-1:0]      rows_t;
  typedef logic [ORDER_W-1:0]     order_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic load_avail;
    logic load_row;
    logic scan_start;
    logic scan_step;
    logic emit_start;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic  scan_last;
    logic  emit_last;
    logic  out_free;
    rows_t row_count;
    rows_t seq_count;
  } status_t;

endpackage

// ----- sv/bsc_ctrl.sv -----
module bsc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_op,
  input  logic             in_last,
  output logic             in_ready,
  input  bsc_pkg::status_t status,
  output bsc_pkg::cmd_t    cmd
);
  import bsc_pkg::*;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_op == OP_AVAIL) begin
            cmd.load_avail = 1'b1;
          end else begin
            cmd.load_row = 1'b1;
            if (in_last) begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          cmd.emit_start = 1'b1;
          state_next     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/bsc_datapath.sv -----
module bsc_datapath (
  input  logic                                      clk,
  input  logic                                      rst,
  input  bsc_pkg::cmd_t                             cmd,
  input  bsc_pkg::count_t [bsc_pkg::RES_TYPES-1:0]  alloc_in,
  input  bsc_pkg::count_t [bsc_pkg::RES_TYPES-1:0]  claim_in,
  input  bsc_pkg::count_t [bsc_pkg::RES_TYPES-1:0]  avail_in,
  input  logic                                      out_ready,
  output bsc_pkg::status_t                          status,
  output logic                                      out_valid,
  output bsc_pkg::order_t                           order_pos,
  output bsc_pkg::order_t                           process_id,
  output logic                                      in_sequence,
  output logic                                      system_safe,
  output logic                                      last_result
);
  import bsc_pkg::*;

  count_t [RES_TYPES-1:0] alloc_mem [NUM_PROCESSES];
  count_t [RES_TYPES-1:0] need_mem  [NUM_PROCESSES];
  proc_t                  seq_mem   [NUM_PROCESSES];
  work_t  [RES_TYPES-1:0] work;
  logic   [NUM_PROCESSES-1:0] finished;
  rows_t                  row_count;
  rows_t                  seq_count;
  proc_t                  idx;
  proc_t                  pass;

  count_t [RES_TYPES-1:0] cur_alloc;
  count_t [RES_TYPES-1:0] cur_need;
  count_t [RES_TYPES-1:0] need_in;
  logic                   fits;
  logic                   grant;
  logic                   idx_wrap;
  logic                   held;
  logic                   room;

  always_comb begin
    cur_alloc = alloc_mem[idx];
    cur_need  = need_mem[idx];
    fits      = 1'b1;
    for (int r = 0; r < RES_TYPES; r++) begin
      if (WORK_W'(cur_need[r]) > work[r]) begin
        fits = 1'b0;
      end
      need_in[r] = (claim_in[r] > alloc_in[r]) ? claim_in[r] - alloc_in[r] : '0;
    end
  end

  assign room     = row_count < ROWS_W'(NUM_PROCESSES);
  assign idx_wrap = (ROWS_W'(idx) + ROWS_W'(1)) >= row_count;
  assign grant    = cmd.scan_step && !finished[idx] && fits && (ROWS_W'(idx) < row_count);
  assign held     = ROWS_W'(idx) < seq_count;

  assign status.scan_last = idx_wrap && (pass == PROC_W'(NUM_PROCESSES - 1));
  assign status.emit_last = idx_wrap;
  assign status.out_free  = !out_valid || out_ready;
  assign status.row_count = row_count;
  assign status.seq_count = seq_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      work      <= '0;
      finished  <= '0;
      row_count <= '0;
      seq_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_avail) begin
        for (int r = 0; r < RES_TYPES; r++) begin
          work[r] <= WORK_W'(avail_in[r]);
        end
      end
      if (cmd.load_row && room) begin
        row_count <= row_count + ROWS_W'(1);
      end
      if (grant) begin
        for (int r = 0; r < RES_TYPES; r++) begin
          work[r] <= work[r] + WORK_W'(cur_alloc[r]);
        end
        finished[idx] <= 1'b1;
        if (seq_count < ROWS_W'(NUM_PROCESSES)) begin
          seq_count <= seq_count + ROWS_W'(1);
        end
      end
      if (cmd.finish) begin
        row_count <= '0;
        seq_count <= '0;
        finished  <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row && room) begin
      alloc_mem[row_count[PROC_W-1:0]] <= alloc_in;
      need_mem[row_count[PROC_W-1:0]]  <= need_in;
    end
    if (grant && (seq_count < ROWS_W'(NUM_PROCESSES))) begin
      seq_mem[seq_count[PROC_W-1:0]] <= idx;
    end
    if (cmd.scan_start || cmd.emit_start) begin
      idx  <= '0;
      pass <= '0;
    end else if (cmd.scan_step || cmd.emit) begin
      idx <= idx_wrap ? '0 : idx + PROC_W'(1);
      if (cmd.scan_step && idx_wrap) begin
        pass <= pass + PROC_W'(1);
      end
    end
    if (cmd.emit) begin
      order_pos   <= ORDER_W'(idx);
      process_id  <= held ? ORDER_W'(seq_mem[idx]) : '0;
      in_sequence <= held;
      system_safe <= idx_wrap && (seq_count == row_count);
      last_result <= idx_wrap;
    end
  end

endmodule

// ----- sv/bankers_safety_check_core.sv -----
// Banker's algorithm safety check over three resource types.
// Requests arrive on the s_axis channel. A request with tuser 0 loads the
// available vector; a request with tuser 1 loads one process row, holding
// its allocation and maximum claim. Rows past the process limit are dropped.
// The row request with tlast set starts the check. The channel takes a new
// request every cycle while idle. The check runs one process per cycle over
// NUM_PROCESSES passes, using a single compare-and-add unit. It then emits
// one result per loaded row on m_axis, one per cycle while the receiver is
// ready, through an output register; the final result has tlast set and
// carries the safe flag. While a check runs or results are being emitted,
// s_axis_tready is low. A stalled receiver holds the current result and
// pauses emission. Reset clears the row count, finished flags, work vector
// and output valid; stored rows are not cleared.
module bankers_safety_check_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // alloc_0, alloc_1, alloc_2, claim_0, claim_1, claim_2, avail_0, avail_1, avail_2
  input  logic [bsc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // op
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // order_pos, process_id, in_sequence, system_safe
  output logic [bsc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);
  import bsc_pkg::*;

  cmd_t                   cmd;
  status_t                status;
  count_t [RES_TYPES-1:0] alloc_in;
  count_t [RES_TYPES-1:0] claim_in;
  count_t [RES_TYPES-1:0] avail_in;
  order_t                 order_pos;
  order_t                 process_id;
  logic                   in_sequence;
  logic                   system_safe;

  always_comb begin
    for (int r = 0; r < RES_TYPES; r++) begin
      alloc_in[r] = COUNT_WIDTH'(s_axis_tdata[r * FIELD_W +: FIELD_W]);
      claim_in[r] = COUNT_WIDTH'(s_axis_tdata[(RES_TYPES + r) * FIELD_W +: FIELD_W]);
      avail_in[r] = COUNT_WIDTH'(s_axis_tdata[(2 * RES_TYPES + r) * FIELD_W +: FIELD_W]);
    end
  end

  assign m_axis_tdata = {system_safe, in_sequence, process_id, order_pos};

  bsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bsc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .alloc_in    (alloc_in),
    .claim_in    (claim_in),
    .avail_in    (avail_in),
    .out_ready   (m_axis_tready),
    .status      (status),
    .out_valid   (m_axis_tvalid),
    .order_pos   (order_pos),
    .process_id  (process_id),
    .in_sequence (in_sequence),
    .system_safe (system_safe),
    .last_result (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_seq_bounded: assert property (@(posedge clk) disable iff (rst)
    status.seq_count <= status.row_count)
    else $error("safe sequence longer than loaded rows");

  a_safe_last_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast && m_axis_tdata[7] |-> m_axis_tdata[6])
    else $error("safe run ends on a position without a granted process");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.emit_last |=> s_axis_tready)
    else $error("input not reopened after final result");

  a_scan_has_rows: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> status.row_count != '0)
    else $error("check running with no loaded rows");
`endif

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  import bsc_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 150;

  typedef logic [IN_DATA_W-1:0] req_data_t;

  typedef struct {
    logic      op;
    logic      last;
    req_data_t data;
    bit        wait_drain;
  } safety_request_t;

  typedef struct {
    logic [2:0] pos;
    logic [2:0] pid;
    logic       in_seq;
    logic       safe;
    logic       last;
  } safety_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  req_data_t             s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  bankers_safety_check_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  safety_request_t pending_requests[$];
  safety_result_t  results_due[$];

  count_t    row_alloc [NUM_PROCESSES][RES_TYPES];
  count_t    row_need  [NUM_PROCESSES][RES_TYPES];
  logic [31:0] work_units [RES_TYPES];
  logic [NUM_PROCESSES-1:0] done_mask = '0;
  int        grant_order [NUM_PROCESSES];
  int        grant_count = 0;
  int        rows_loaded = 0;

  int  requests_total = 0;
  int  requests_taken = 0;
  int  checks_run = 0;
  int  safe_checks = 0;
  int  results_seen = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  req_taken = 0;
  bit  calm = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    for (int r = 0; r < RES_TYPES; r++) work_units[r] = '0;
  end

  function automatic req_data_t pack9(input count_t a0, a1, a2, c0, c1, c2, v0, v1, v2);
    req_data_t d;
    d = '0;
    d[0*FIELD_W +: COUNT_WIDTH] = a0;
    d[1*FIELD_W +: COUNT_WIDTH] = a1;
    d[2*FIELD_W +: COUNT_WIDTH] = a2;
    d[3*FIELD_W +: COUNT_WIDTH] = c0;
    d[4*FIELD_W +: COUNT_WIDTH] = c1;
    d[5*FIELD_W +: COUNT_WIDTH] = c2;
    d[6*FIELD_W +: COUNT_WIDTH] = v0;
    d[7*FIELD_W +: COUNT_WIDTH] = v1;
    d[8*FIELD_W +: COUNT_WIDTH] = v2;
    return d;
  endfunction

  function automatic count_t rand_count(input int scale);
    case (scale)
      0: return count_t'($urandom_range(0, 7));
      1: return count_t'($urandom_range(0, 255));
      2: return count_t'($urandom);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  function automatic req_data_t rand_bits();
    req_data_t d;
    for (int i = 0; i < IN_DATA_W; i += 16) d[i +: 16] = 16'($urandom);
    return d;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_request(input logic op, input logic last, input req_data_t data,
                             input bit wait_drain);
    safety_request_t q;
    q.op = op;
    q.last = last;
    q.data = data;
    q.wait_drain = wait_drain;
    pending_requests.push_back(q);
  endtask

  task automatic add_avail(input int scale, input logic last, input bit wait_drain);
    req_data_t d;
    d = rand_bits();
    for (int r = 0; r < RES_TYPES; r++) d[(6 + r)*FIELD_W +: FIELD_W] = rand_count(scale);
    add_request(OP_AVAIL, last, d, wait_drain);
  endtask

  task automatic add_row(input int scale, input logic last, input bit wait_drain);
    req_data_t d;
    d = rand_bits();
    for (int r = 0; r < 6; r++) d[r*FIELD_W +: FIELD_W] = rand_count(scale);
    add_request(OP_ROW, last, d, wait_drain);
  endtask

  task automatic predict_request(input logic op, input logic last, input req_data_t data);
    count_t         a;
    count_t         c;
    bit             fits;
    bit             held;
    int             n;
    safety_result_t res;
    if (op == OP_AVAIL) begin
      for (int r = 0; r < RES_TYPES; r++) begin
        work_units[r] = 32'(data[(6 + r)*FIELD_W +: COUNT_WIDTH]);
      end
    end else begin
      if (rows_loaded < NUM_PROCESSES) begin
        for (int r = 0; r < RES_TYPES; r++) begin
          a = data[r*FIELD_W +: COUNT_WIDTH];
          c = data[(3 + r)*FIELD_W +: COUNT_WIDTH];
          row_alloc[rows_loaded][r] = a;
          row_need[rows_loaded][r] = (c > a) ? c - a : '0;
        end
        rows_loaded++;
      end
      if (last) begin
        for (int pass = 0; pass < NUM_PROCESSES; pass++) begin
          for (int p = 0; p < rows_loaded; p++) begin
            fits = !done_mask[p];
            for (int r = 0; r < RES_TYPES; r++) begin
              if (32'(row_need[p][r]) > work_units[r]) fits = 0;
            end
            if (fits) begin
              for (int r = 0; r < RES_TYPES; r++) begin
                work_units[r] += 32'(row_alloc[p][r]);
              end
              done_mask[p] = 1'b1;
              grant_order[grant_count] = p;
              grant_count++;
            end
          end
        end
        n = (rows_loaded > 0) ? rows_loaded : 1;
        for (int k = 0; k < n; k++) begin
          held = k < grant_count;
          res.pos = k[2:0];
          res.pid = held ? grant_order[k][2:0] : 3'd0;
          res.in_seq = held;
          res.last = (k == n - 1);
          res.safe = res.last && (grant_count == rows_loaded);
          results_due.push_back(res);
        end
        checks_run++;
        if (grant_count == rows_loaded) safe_checks++;
        rows_loaded = 0;
        grant_count = 0;
        done_mask = '0;
      end
    end
  endtask

  task automatic report_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin : drive
    safety_request_t q;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !req_taken) begin
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_requests.size() != 0 && pending_requests[0].wait_drain &&
                 results_due.size() != 0) begin
      s_axis_tvalid <= 1'b0;
    end else if (pending_requests.size() != 0) begin
      q = pending_requests.pop_front();
      s_axis_tdata <= q.data;
      s_axis_tuser <= q.op;
      s_axis_tlast <= q.last;
      s_axis_tvalid <= 1'b1;
      gap_left = calm ? 0 : pick_gap();
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin : receive
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : watch
    safety_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, results_due.size());
      $display("** bankers_safety_check_core: FAILED **");
      $finish;
    end else begin
      if ($urandom_range(0, 299) == 0) calm = !calm;
      req_taken = s_axis_tvalid && s_axis_tready && !rst;
      if (req_taken) begin
        predict_request(s_axis_tuser, s_axis_tlast, s_axis_tdata);
        requests_taken++;
      end
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got tdata 0x%02h tlast %0b",
                   $time, m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          report_field("order_pos", want.pos, m_axis_tdata[2:0]);
          report_field("process_id", want.pid, m_axis_tdata[5:3]);
          report_field("in_sequence", want.in_seq, m_axis_tdata[6]);
          report_field("system_safe", want.safe, m_axis_tdata[7]);
          report_field("last_result", want.last, m_axis_tlast);
        end
      end
    end
  end

  initial begin : stimulus
    int kind;
    int scale;
    int nrows;
    int split;
    bit drain;

    // Load of the available vector; tlast on it must be ignored.
    add_request(OP_AVAIL, 1'b1, pack9(0, 0, 0, 0, 0, 0, '1, '1, '1), 0);
    add_request(OP_ROW, 1'b1, pack9(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    // Zero work: a row with zero need unlocks one with the largest need.
    add_request(OP_AVAIL, 1'b0, pack9(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    add_request(OP_ROW, 1'b0, pack9('1, '1, '1, '1, '1, '1, 0, 0, 0), 0);
    add_request(OP_ROW, 1'b1, pack9(0, 0, 0, '1, '1, '1, 0, 0, 0), 0);
    // Claim below allocation saturates the need at zero.
    add_request(OP_AVAIL, 1'b0, pack9(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    add_request(OP_ROW, 1'b0, pack9(5, 0, 7, 1, 0, 2, 0, 0, 0), 0);
    add_request(OP_ROW, 1'b1, pack9(0, 0, 0, 5, 0, 7, 0, 0, 0), 0);
    // A single process that can never be served.
    add_request(OP_AVAIL, 1'b0, pack9(0, 0, 0, 0, 0, 0, 1, 1, 1), 1);
    add_request(OP_ROW, 1'b1, pack9(0, 0, 0, 10, 0, 0, 0, 0, 0), 0);
    // Full table granted in reverse order, one grant per pass, then a
    // ninth row that is dropped but still starts the check.
    add_request(OP_AVAIL, 1'b0, pack9(0, 0, 0, 0, 0, 0, 1, 1, 1), 0);
    for (int i = 0; i < NUM_PROCESSES; i++) begin
      add_request(OP_ROW, 1'b0,
                  pack9(1, 1, 1, count_t'(9 - i), count_t'(9 - i), count_t'(9 - i), 0, 0, 0), 0);
    end
    add_request(OP_ROW, 1'b1, pack9(0, 0, 0, '1, '1, '1, 0, 0, 0), 0);
    // The work vector keeps its grown value into the next check.
    add_request(OP_ROW, 1'b1, pack9(0, 0, 0, 9, 9, 9, 0, 0, 0), 0);
    // One resource short: partial sequence, unsafe.
    add_request(OP_AVAIL, 1'b0, pack9(0, 0, 0, 0, 0, 0, 2, 0, 2), 0);
    add_request(OP_ROW, 1'b0, pack9(1, 1, 1, 2, 2, 2, 0, 0, 0), 0);
    add_request(OP_ROW, 1'b1, pack9(0, 0, 0, 1, 0, 1, 0, 0, 0), 0);

    while (pending_requests.size() < 225) begin
      kind = $urandom_range(0, 9);
      scale = $urandom_range(0, 3);
      drain = ($urandom_range(0, 5) == 0);
      if (kind == 0) begin
        add_request(OP_AVAIL, 1'($urandom_range(0, 1)), rand_bits(), drain);
      end else begin
        nrows = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
        split = (kind == 2) ? $urandom_range(0, nrows - 1) : -1;
        if (kind != 1) add_avail(scale, 1'($urandom_range(0, 1)), drain);
        for (int i = 0; i < nrows; i++) begin
          if (i == split) add_avail(scale, 1'b0, 0);
          add_row(scale, i == nrows - 1, (kind == 1) && (i == 0) && drain);
        end
      end
    end
    requests_total = pending_requests.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (requests_taken < requests_total) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests, ran %0d safety checks (%0d safe, %0d unsafe).",
             requests_taken, checks_run, safe_checks, checks_run - safe_checks);
    $display("Compared %0d results, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("** bankers_safety_check_core: PASSED **");
    end else begin
      $display("** bankers_safety_check_core: FAILED **");
    end
    $finish;
  end

endmodule
